FILE: sv/rpt_pkg.sv
// rpt_pkg: shared types, codes and constants for the RSSI proximity tracker.
// No dependencies; used by rpt_mac, rssi_proximity_tracker and the testbench.
`default_nettype none

package rpt_pkg;

	// sample history ring
	localparam int HIST_DEPTH = 8;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

	// shared multiply-accumulate unit
	localparam int MAC_OP_W = 18;
	localparam int ACC_W    = 2 * MAC_OP_W;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR_HERE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR_CLOSE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THR_NEAR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THR_FAR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 3'd5;

	// register reset values
	localparam logic [8:0]        WEIGHT_RST    = 9'd77;
	localparam logic signed [7:0] THR_HERE_RST  = -8'sd80;
	localparam logic signed [7:0] THR_CLOSE_RST = -8'sd87;
	localparam logic signed [7:0] THR_NEAR_RST  = -8'sd93;
	localparam logic signed [7:0] THR_FAR_RST   = -8'sd100;
	localparam logic [6:0]        MARGIN_RST    = 7'd3;

	// smoothed value reset: -80 dBm in Q8.8
	localparam logic signed [15:0] SMOOTH_RST = -16'sd20480;
	localparam logic [8:0]         WEIGHT_ONE = 9'd256;
	localparam logic [9:0]         Q8_ONE     = 10'd256;

	// colour / arc map: d = s + 26880 clamped to 0..7680 (-105..-75 dBm)
	localparam logic signed [16:0] D_OFFSET   = 17'sd26880;
	localparam logic [12:0]        D_SPAN     = 13'd7680;
	localparam logic [12:0]        D_MID      = 13'd3840;
	localparam logic [17:0]        RECIP3     = 18'd43691;
	localparam logic [7:0]         GREEN_BASE = 8'd220;
	localparam logic [7:0]         RED_FULL   = 8'd255;
	localparam logic [7:0]         BLUE_ON    = 8'd40;
	localparam logic [7:0]         GREY       = 8'd60;
	localparam logic [FILL_W-1:0]  TREND_MIN_FILL = FILL_W'(3);

	localparam logic [2:0] PROX_NONE     = 3'd0;
	localparam logic [2:0] PROX_HERE     = 3'd1;
	localparam logic [2:0] PROX_CLOSE    = 3'd2;
	localparam logic [2:0] PROX_NEARBY   = 3'd3;
	localparam logic [2:0] PROX_FAR      = 3'd4;
	localparam logic [2:0] PROX_VERY_FAR = 3'd5;

	localparam logic [1:0] TREND_NONE    = 2'd0;
	localparam logic [1:0] TREND_CLOSER  = 2'd1;
	localparam logic [1:0] TREND_FARTHER = 2'd2;

	typedef enum logic [1:0] {
		MAC_HOLD,
		MAC_LOAD,
		MAC_ADD
	} mac_op_t;

	typedef struct packed {
		mac_op_t                     op;
		logic signed [MAC_OP_W-1:0]  a;
		logic signed [MAC_OP_W-1:0]  b;
	} mac_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_NEW,
		ST_MUL_OLD,
		ST_SMOOTH,
		ST_CLAMP,
		ST_ARC,
		ST_RED,
		ST_GRN_A,
		ST_GRN_B,
		ST_GRN_C,
		ST_LIM,
		ST_TRD,
		ST_CMP,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: sv/rpt_ram.sv
// rpt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/rpt_mac.sv
// rpt_mac: shared signed multiply-accumulate unit, one product per cycle.
// Depends on rpt_pkg.
`default_nettype none

module rpt_mac (
	input  wire logic                            clk,
	input  wire rpt_pkg::mac_req_t               req,
	output logic signed [rpt_pkg::ACC_W-1:0]     acc
);

	logic signed [rpt_pkg::ACC_W-1:0] prod;

	assign prod = req.a * req.b;

	always_ff @(posedge clk) begin
		case (req.op)
			rpt_pkg::MAC_LOAD: acc <= prod;
			rpt_pkg::MAC_ADD:  acc <= acc + prod;
			default:           acc <= acc;
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/rssi_proximity_tracker.sv
// rssi_proximity_tracker: top level. Sequencer, state and output register.
// Depends on rpt_pkg, rpt_mac and rpt_ram.
`default_nettype none

// One RSSI sample (signed dBm) is taken per transfer on the s_ side and one result
// transfer leaves on the m_ side. A sample of 0 reports "not connected" (zone 0,
// empty grey ring) and keeps the smoothed value and history; any other sample
// seeds or updates a Q8.8 exponential moving average, is pushed into an
// eight-entry ring, and yields zone, trend, arc and ring colour. All products
// (average blend, arc and colour maps, trend margin) run one per cycle through a
// single shared multiply-accumulate unit, and the trend sums walk the history
// RAM one entry per cycle; that walk runs only once three or more samples are
// held. s_tready is high only while the sequencer is idle, so it is low while an
// item is worked on. The result sits in an output register, so a new sample is
// taken while the last result waits; a finished result that still finds the
// register full holds the sequencer in its last state. Configuration writes
// (cfg_we, cfg_index, cfg_data) are only to be issued while idle; the block
// itself does not enforce this.

module rssi_proximity_tracker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// sample stream
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [7:0]                         s_tdata,   // [7:0] rssi_sample
	// result stream
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// [2:0] zone, [4:3] trend, [20:5] smoothed_q8, [29:21] arc_degrees,
	// [37:30] ring_red, [45:38] ring_green, [53:46] ring_blue, [55:54] zero
	output logic [55:0]                             m_tdata,
	output logic                                    m_tuser,   // [0] connected
	// configuration
	input  wire logic                               cfg_we,
	input  wire logic [rpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rpt_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW = rpt_pkg::HIST_AW;
	localparam int FW = rpt_pkg::FILL_W;
	localparam logic [AW:0] DEPTH_V = (AW + 1)'(rpt_pkg::HIST_DEPTH);

	// configuration registers
	logic [8:0]        weight_q;
	logic signed [7:0] thr_here_q;
	logic signed [7:0] thr_close_q;
	logic signed [7:0] thr_near_q;
	logic signed [7:0] thr_far_q;
	logic [6:0]        margin_q;

	// sequencer and tracker state
	rpt_pkg::state_t   state_q, state_d;
	logic              have_q;
	logic signed [15:0] s_q;
	logic [AW-1:0]     slot_q;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     k_q;

	// per-item working registers
	logic signed [7:0] x_q;
	logic              conn_q;
	logic [12:0]       d_q;
	logic [2:0]        zone_q;
	logic [1:0]        trend_q;
	logic [8:0]        arc_q;
	logic [7:0]        red_q;
	logic [7:0]        green_q;
	logic signed [15:0] lim_q;

	// output register
	logic              out_valid_q;
	logic [55:0]       out_data_q;
	logic              out_user_q;

	// shared unit and history RAM
	rpt_pkg::mac_req_t mac_req;
	logic signed [rpt_pkg::ACC_W-1:0] acc;
	logic              ram_we;
	logic [AW-1:0]     ram_raddr;
	logic [7:0]        ram_rdata;

	logic              accept;
	logic              sample_nz;
	logic              out_free;
	logic [8:0]        w_eff;
	logic [9:0]        w_inv;
	logic signed [16:0] d_raw;
	logic [12:0]       d_clamp;
	logic [2:0]        zone_d;
	logic              d_low;
	logic [10:0]       grn_n;
	logic [7:0]        grn_g;
	logic [FW-1:0]     half;
	logic [FW-1:0]     half2;
	logic [FW-1:0]     rd_off;
	logic [AW:0]       base_raw, base, addr_raw;
	logic signed [rpt_pkg::ACC_W-1:0] round_sum;
	logic signed [15:0] diff;

	assign accept    = s_tvalid && s_tready;
	assign sample_nz = (s_tdata != 8'd0);
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == rpt_pkg::ST_IDLE);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// weight above 1.0 acts as 1.0
	assign w_eff = (weight_q > rpt_pkg::WEIGHT_ONE) ? rpt_pkg::WEIGHT_ONE : weight_q;
	assign w_inv = rpt_pkg::Q8_ONE - {1'b0, w_eff};

	// map input: -105..-75 dBm onto 0..7680
	assign d_raw = {s_q[15], s_q} + rpt_pkg::D_OFFSET;
	always_comb begin
		if (d_raw < 0) begin
			d_clamp = 13'd0;
		end else if (d_raw > $signed({4'b0, rpt_pkg::D_SPAN})) begin
			d_clamp = rpt_pkg::D_SPAN;
		end else begin
			d_clamp = d_raw[12:0];
		end
	end
	assign d_low = (d_q < rpt_pkg::D_MID);

	// zone: fixed test order regardless of threshold ordering
	always_comb begin
		if (s_q >= $signed({thr_here_q, 8'h00})) begin
			zone_d = rpt_pkg::PROX_HERE;
		end else if (s_q >= $signed({thr_close_q, 8'h00})) begin
			zone_d = rpt_pkg::PROX_CLOSE;
		end else if (s_q >= $signed({thr_near_q, 8'h00})) begin
			zone_d = rpt_pkg::PROX_NEARBY;
		end else if (s_q >= $signed({thr_far_q, 8'h00})) begin
			zone_d = rpt_pkg::PROX_FAR;
		end else begin
			zone_d = rpt_pkg::PROX_VERY_FAR;
		end
	end

	// green: floor(n/3) by reciprocal, n = d*11>>6 (low half) or (d-3840)*7>>8
	assign grn_n = d_low ? {1'b0, acc[15:6]} : {3'b0, acc[15:8]};
	assign grn_g = acc[24:17];

	assign round_sum = acc + rpt_pkg::ACC_W'(128);
	assign diff      = acc[15:0];

	// history walk: oldest half first, then newest half
	assign half     = fill_q >> 1;
	assign half2    = half << 1;
	assign rd_off   = k_q + ((k_q >= half) ? FW'(fill_q[0]) : FW'(0));
	assign base_raw = {1'b0, slot_q} + DEPTH_V - (AW + 1)'(fill_q);
	assign base     = (base_raw >= DEPTH_V) ? base_raw - DEPTH_V : base_raw;
	assign addr_raw = base + (AW + 1)'(rd_off);
	assign ram_raddr = (addr_raw >= DEPTH_V) ? AW'(addr_raw - DEPTH_V) : addr_raw[AW-1:0];
	assign ram_we   = accept && sample_nz;

	rpt_mac u_mac (
		.clk (clk),
		.req (mac_req),
		.acc (acc)
	);

	rpt_ram #(
		.WIDTH (8),
		.DEPTH (rpt_pkg::HIST_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (s_tdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rpt_pkg::ST_IDLE: begin
				if (accept) begin
					if (!sample_nz) begin
						state_d = rpt_pkg::ST_DONE;
					end else if (have_q) begin
						state_d = rpt_pkg::ST_MUL_NEW;
					end else begin
						state_d = rpt_pkg::ST_CLAMP;
					end
				end
			end
			rpt_pkg::ST_MUL_NEW: state_d = rpt_pkg::ST_MUL_OLD;
			rpt_pkg::ST_MUL_OLD: state_d = rpt_pkg::ST_SMOOTH;
			rpt_pkg::ST_SMOOTH:  state_d = rpt_pkg::ST_CLAMP;
			rpt_pkg::ST_CLAMP:   state_d = rpt_pkg::ST_ARC;
			rpt_pkg::ST_ARC:     state_d = rpt_pkg::ST_RED;
			rpt_pkg::ST_RED:     state_d = rpt_pkg::ST_GRN_A;
			rpt_pkg::ST_GRN_A:   state_d = rpt_pkg::ST_GRN_B;
			rpt_pkg::ST_GRN_B:   state_d = rpt_pkg::ST_GRN_C;
			rpt_pkg::ST_GRN_C: begin
				if (fill_q >= rpt_pkg::TREND_MIN_FILL) begin
					state_d = rpt_pkg::ST_LIM;
				end else begin
					state_d = rpt_pkg::ST_DONE;
				end
			end
			rpt_pkg::ST_LIM: state_d = rpt_pkg::ST_TRD;
			rpt_pkg::ST_TRD: begin
				if (k_q == half2) begin
					state_d = rpt_pkg::ST_CMP;
				end
			end
			rpt_pkg::ST_CMP: state_d = rpt_pkg::ST_DONE;
			rpt_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = rpt_pkg::ST_IDLE;
				end
			end
			default: state_d = rpt_pkg::ST_IDLE;
		endcase
	end

	// shared unit operand select
	always_comb begin
		mac_req.op = rpt_pkg::MAC_HOLD;
		mac_req.a  = '0;
		mac_req.b  = '0;
		case (state_q)
			rpt_pkg::ST_MUL_NEW: begin
				mac_req.op = rpt_pkg::MAC_LOAD;
				mac_req.a  = $signed({9'b0, w_eff});
				mac_req.b  = $signed({{2{x_q[7]}}, x_q, 8'h00});
			end
			rpt_pkg::ST_MUL_OLD: begin
				mac_req.op = rpt_pkg::MAC_ADD;
				mac_req.a  = $signed({8'b0, w_inv});
				mac_req.b  = $signed({{2{s_q[15]}}, s_q});
			end
			rpt_pkg::ST_ARC: begin
				mac_req.op = rpt_pkg::MAC_LOAD;
				mac_req.a  = $signed({5'b0, d_q});
				mac_req.b  = 18'sd12;
			end
			rpt_pkg::ST_RED: begin
				mac_req.op = rpt_pkg::MAC_LOAD;
				mac_req.a  = $signed({5'b0, rpt_pkg::D_SPAN - d_q});
				mac_req.b  = 18'sd17;
			end
			rpt_pkg::ST_GRN_A: begin
				mac_req.op = rpt_pkg::MAC_LOAD;
				mac_req.a  = d_low ? $signed({5'b0, d_q})
				                   : $signed({5'b0, d_q - rpt_pkg::D_MID});
				mac_req.b  = d_low ? 18'sd11 : 18'sd7;
			end
			rpt_pkg::ST_GRN_B: begin
				mac_req.op = rpt_pkg::MAC_LOAD;
				mac_req.a  = $signed({7'b0, grn_n});
				mac_req.b  = $signed(rpt_pkg::RECIP3);
			end
			rpt_pkg::ST_LIM: begin
				mac_req.op = rpt_pkg::MAC_LOAD;
				mac_req.a  = $signed({11'b0, margin_q});
				mac_req.b  = $signed({14'b0, half});
			end
			rpt_pkg::ST_TRD: begin
				// data for entry k-1 arrives now; older half subtracts
				if (k_q != FW'(0)) begin
					mac_req.op = (k_q == FW'(1)) ? rpt_pkg::MAC_LOAD : rpt_pkg::MAC_ADD;
					mac_req.a  = $signed({{10{ram_rdata[7]}}, ram_rdata});
					mac_req.b  = (k_q > half) ? 18'sd1 : -18'sd1;
				end
			end
			default: begin
				mac_req.op = rpt_pkg::MAC_HOLD;
			end
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpt_pkg::ST_IDLE;
			have_q      <= 1'b0;
			s_q         <= rpt_pkg::SMOOTH_RST;
			slot_q      <= '0;
			fill_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			weight_q    <= rpt_pkg::WEIGHT_RST;
			thr_here_q  <= rpt_pkg::THR_HERE_RST;
			thr_close_q <= rpt_pkg::THR_CLOSE_RST;
			thr_near_q  <= rpt_pkg::THR_NEAR_RST;
			thr_far_q   <= rpt_pkg::THR_FAR_RST;
			margin_q    <= rpt_pkg::MARGIN_RST;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					rpt_pkg::REG_WEIGHT:    weight_q    <= cfg_data;
					rpt_pkg::REG_THR_HERE:  thr_here_q  <= cfg_data[7:0];
					rpt_pkg::REG_THR_CLOSE: thr_close_q <= cfg_data[7:0];
					rpt_pkg::REG_THR_NEAR:  thr_near_q  <= cfg_data[7:0];
					rpt_pkg::REG_THR_FAR:   thr_far_q   <= cfg_data[7:0];
					rpt_pkg::REG_MARGIN:    margin_q    <= cfg_data[6:0];
					default: ;
				endcase
			end

			if (accept) begin
				if (!sample_nz) begin
					have_q <= 1'b0;
				end else begin
					slot_q <= (slot_q == AW'(rpt_pkg::HIST_DEPTH - 1)) ? '0 : slot_q + 1'b1;
					if (fill_q < FW'(rpt_pkg::HIST_DEPTH)) begin
						fill_q <= fill_q + 1'b1;
					end
					if (!have_q) begin
						// first reading seeds the average
						s_q    <= {s_tdata, 8'h00};
						have_q <= 1'b1;
					end
				end
			end

			if (state_q == rpt_pkg::ST_SMOOTH) begin
				s_q <= round_sum[23:8];
			end

			if (state_q == rpt_pkg::ST_LIM) begin
				k_q <= '0;
			end else if (state_q == rpt_pkg::ST_TRD) begin
				k_q <= k_q + 1'b1;
			end

			if (state_q == rpt_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// per-item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= s_tdata;
			conn_q <= sample_nz;
		end

		case (state_q)
			rpt_pkg::ST_CLAMP: begin
				d_q    <= d_clamp;
				zone_q <= zone_d;
			end
			rpt_pkg::ST_RED: begin
				arc_q <= acc[16:8];
			end
			rpt_pkg::ST_GRN_A: begin
				red_q <= d_low ? rpt_pkg::RED_FULL : acc[15:8];
			end
			rpt_pkg::ST_GRN_C: begin
				green_q <= d_low ? grn_g : rpt_pkg::GREEN_BASE + grn_g;
				trend_q <= rpt_pkg::TREND_NONE;
			end
			rpt_pkg::ST_TRD: begin
				if (k_q == FW'(0)) begin
					lim_q <= acc[15:0];
				end
			end
			rpt_pkg::ST_CMP: begin
				if (diff > lim_q) begin
					trend_q <= rpt_pkg::TREND_CLOSER;
				end else if (diff < -lim_q) begin
					trend_q <= rpt_pkg::TREND_FARTHER;
				end else begin
					trend_q <= rpt_pkg::TREND_NONE;
				end
			end
			default: ;
		endcase

		if (state_q == rpt_pkg::ST_DONE && out_free) begin
			out_user_q <= conn_q;
			if (conn_q) begin
				out_data_q <= {2'b00, rpt_pkg::BLUE_ON, green_q, red_q, arc_q, s_q,
				               trend_q, zone_q};
			end else begin
				out_data_q <= {2'b00, rpt_pkg::GREY, rpt_pkg::GREY, rpt_pkg::GREY, 9'd0,
				               s_q, rpt_pkg::TREND_NONE, rpt_pkg::PROX_NONE};
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(rpt_pkg::HIST_DEPTH))
		else $error("history fill beyond depth");

	a_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sample_nz) |=> have_q)
		else $error("reading flag not set after a valid sample");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rpt_pkg::ST_TRD) |-> (k_q <= half2))
		else $error("history walk ran past its end");

	a_walk_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rpt_pkg::ST_LIM) |-> (fill_q >= rpt_pkg::TREND_MIN_FILL))
		else $error("trend started with too few samples");

	a_disc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !sample_nz) |=> ($stable(s_q) && !have_q))
		else $error("disconnect disturbed the average");
`endif

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// testbench: self-checking bench for rssi_proximity_tracker (sample stream in,
// result stream out, plain register port). A local model predicts every result.
// Depends on rpt_pkg and the RTL only.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// one result transfer, fields as the block reports them
	typedef struct packed {
		logic               connected;
		logic [2:0]         zone;
		logic [1:0]         trend;
		logic signed [15:0] smooth_q8;
		logic [8:0]         arc;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} reading_t;

	// directed plan entry: a register write or a sample, optionally with a typed result
	typedef struct {
		logic                           is_write;
		logic [rpt_pkg::CFG_IDX_W-1:0]  idx;
		logic [rpt_pkg::CFG_DATA_W-1:0] value;
		logic                           known;
		reading_t                       want;
	} plan_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [55:0]                    m_tdata;
	logic                           m_tuser;
	logic                           cfg_we = 1'b0;
	logic [rpt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rpt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	rssi_proximity_tracker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Local copy of the tracker: registers and state
	// ------------------------------------------------------------------
	logic [8:0]        weight_q8  = rpt_pkg::WEIGHT_RST;
	logic signed [7:0] lim_here   = rpt_pkg::THR_HERE_RST;
	logic signed [7:0] lim_close  = rpt_pkg::THR_CLOSE_RST;
	logic signed [7:0] lim_near   = rpt_pkg::THR_NEAR_RST;
	logic signed [7:0] lim_far    = rpt_pkg::THR_FAR_RST;
	logic [6:0]        margin_db  = rpt_pkg::MARGIN_RST;

	int   avg_q8 = rpt_pkg::SMOOTH_RST;     // smoothed dBm, Q8.8
	logic have_reading = 1'b0;
	int   hist [rpt_pkg::HIST_DEPTH];       // raw samples, only written slots are read
	int   hist_slot = 0;
	int   hist_fill = 0;

	reading_t awaited [$];         // results still owed by the block
	int       mismatches = 0;

	reading_t got, want;

	function automatic reading_t mk_reading(input logic c, input logic [2:0] zone,
			input logic [1:0] trend, input int s, input int arc, input int red,
			input int green, input int blue);
		reading_t r;
		r.connected = c;
		r.zone      = zone;
		r.trend     = trend;
		r.smooth_q8 = 16'(s);
		r.arc       = 9'(arc);
		r.red       = 8'(red);
		r.green     = 8'(green);
		r.blue      = 8'(blue);
		return r;
	endfunction

	// Advance the local tracker by one sample and return the result it owes.
	function automatic reading_t predict_reading(input logic signed [7:0] x);
		reading_t r;
		int xi, w, acc, d, h, base, oldest, newest, lim;
		xi = x;
		r = '0;
		if (xi == 0) begin
			// link down: grey empty ring, average and history held
			have_reading = 1'b0;
			return mk_reading(1'b0, rpt_pkg::PROX_NONE, rpt_pkg::TREND_NONE, avg_q8, 0,
				rpt_pkg::GREY, rpt_pkg::GREY, rpt_pkg::GREY);
		end
		if (!have_reading) begin
			avg_q8 = xi * 256;
			have_reading = 1'b1;
		end else begin
			w = weight_q8;
			if (w > 256)
				w = 256;
			acc = w * (xi * 256) + (256 - w) * avg_q8;
			avg_q8 = (acc + 128) >>> 8;
		end

		hist[hist_slot] = xi;
		hist_slot = (hist_slot + 1) % rpt_pkg::HIST_DEPTH;
		if (hist_fill < rpt_pkg::HIST_DEPTH)
			hist_fill++;

		r.connected = 1'b1;
		r.smooth_q8 = 16'(avg_q8);
		if (avg_q8 >= int'(lim_here) * 256)
			r.zone = rpt_pkg::PROX_HERE;
		else if (avg_q8 >= int'(lim_close) * 256)
			r.zone = rpt_pkg::PROX_CLOSE;
		else if (avg_q8 >= int'(lim_near) * 256)
			r.zone = rpt_pkg::PROX_NEARBY;
		else if (avg_q8 >= int'(lim_far) * 256)
			r.zone = rpt_pkg::PROX_FAR;
		else
			r.zone = rpt_pkg::PROX_VERY_FAR;

		// -105..-75 dBm mapped onto 0..7680
		d = avg_q8 + 26880;
		if (d < 0)
			d = 0;
		if (d > 7680)
			d = 7680;
		r.arc = 9'((d * 12) >> 8);
		if (d < 3840) begin
			r.red   = rpt_pkg::RED_FULL;
			r.green = 8'(d * 11 / 192);
		end else begin
			r.red   = 8'(((7680 - d) * 17) >> 8);
			r.green = 8'(220 + (d - 3840) * 7 / 768);
		end
		r.blue = rpt_pkg::BLUE_ON;

		// newest half of the history against the oldest half
		r.trend = rpt_pkg::TREND_NONE;
		if (hist_fill >= 3) begin
			h = hist_fill / 2;
			base = hist_slot + rpt_pkg::HIST_DEPTH - hist_fill;
			oldest = 0;
			newest = 0;
			for (int i = 0; i < h; i++)
				oldest += hist[(base + i) % rpt_pkg::HIST_DEPTH];
			for (int i = hist_fill - h; i < hist_fill; i++)
				newest += hist[(base + i) % rpt_pkg::HIST_DEPTH];
			lim = int'(margin_db) * h;
			if (newest - oldest > lim)
				r.trend = rpt_pkg::TREND_CLOSER;
			else if (newest - oldest < -lim)
				r.trend = rpt_pkg::TREND_FARTHER;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Drivers (change on the falling edge)
	// ------------------------------------------------------------------

	// Offer one sample; on the transfer, predict and queue the owed result.
	task automatic send_sample(input logic signed [7:0] x, input logic known,
			input reading_t typed);
		reading_t r;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= x;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = predict_reading(x);
		awaited.push_back(known ? typed : r);
	endtask

	// Stop sending and let every owed result drain before touching registers.
	task automatic quiesce();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rpt_pkg::CFG_IDX_W-1:0] idx,
			input logic [rpt_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rpt_pkg::REG_WEIGHT:    weight_q8 = val;
			rpt_pkg::REG_THR_HERE:  lim_here  = val[7:0];
			rpt_pkg::REG_THR_CLOSE: lim_close = val[7:0];
			rpt_pkg::REG_THR_NEAR:  lim_near  = val[7:0];
			rpt_pkg::REG_THR_FAR:   lim_far   = val[7:0];
			rpt_pkg::REG_MARGIN:    margin_db = val[6:0];
			default: ;
		endcase
	endtask

	function automatic plan_row_t sample_row(input logic signed [7:0] x);
		plan_row_t p;
		p.is_write = 1'b0;
		p.idx      = '0;
		p.value    = {1'b0, x};
		p.known    = 1'b0;
		p.want     = '0;
		return p;
	endfunction

	function automatic plan_row_t known_row(input logic signed [7:0] x, input reading_t r);
		plan_row_t p;
		p = sample_row(x);
		p.known = 1'b1;
		p.want  = r;
		return p;
	endfunction

	function automatic plan_row_t write_row(input logic [rpt_pkg::CFG_IDX_W-1:0] idx,
			input logic [rpt_pkg::CFG_DATA_W-1:0] val);
		plan_row_t p;
		p.is_write = 1'b1;
		p.idx      = idx;
		p.value    = val;
		p.known    = 1'b0;
		p.want     = '0;
		return p;
	endfunction

	// ------------------------------------------------------------------
	// Result side: stall pattern and checker
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int stall_left = 0;
	int stall_tick = 0;

	// modes: always ready, coin flip, mostly stalled, periodic bursts
	always @(negedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(40, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= stall_tick[2];
		endcase
	end

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited.size() == 0) begin
				$display("%0t result with nothing owed: tuser %0b tdata %h",
					$time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = awaited.pop_front();
				// tdata: zone, trend, smoothed, arc, red, green, blue from bit 0 up
				got.connected = m_tuser;
				got.zone      = m_tdata[2:0];
				got.trend     = m_tdata[4:3];
				got.smooth_q8 = m_tdata[20:5];
				got.arc       = m_tdata[29:21];
				got.red       = m_tdata[37:30];
				got.green     = m_tdata[45:38];
				got.blue      = m_tdata[53:46];
				check_field("connected", want.connected, got.connected);
				check_field("zone", want.zone, got.zone);
				check_field("trend", want.trend, got.trend);
				check_field("smoothed_q8", int'(want.smooth_q8), int'(got.smooth_q8));
				check_field("arc_degrees", want.arc, got.arc);
				check_field("ring_red", want.red, got.red);
				check_field("ring_green", want.green, got.green);
				check_field("ring_blue", want.blue, got.blue);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	plan_row_t plan [$];

	initial begin
		int level, dir, burst, gap, roll;
		logic signed [7:0] x, t_here, t_close, t_near, t_far;
		logic [8:0] w;
		logic [6:0] mg;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed part. Typed results: link down right after reset, seeding on
		// the floor sample, reseeding after a drop, and full-weight updates that
		// land exactly on the low map end and the midpoint.
		plan.push_back(known_row(8'sd0,
			mk_reading(1'b0, rpt_pkg::PROX_NONE, rpt_pkg::TREND_NONE, rpt_pkg::SMOOTH_RST,
				0, rpt_pkg::GREY, rpt_pkg::GREY, rpt_pkg::GREY)));
		plan.push_back(known_row(-8'sd128,
			mk_reading(1'b1, rpt_pkg::PROX_VERY_FAR, rpt_pkg::TREND_NONE, -32768, 0,
				rpt_pkg::RED_FULL, 0, rpt_pkg::BLUE_ON)));
		plan.push_back(sample_row(8'sd127));           // positive reading, blended
		plan.push_back(sample_row(8'sd0));             // drop: average held
		plan.push_back(known_row(-8'sd60,              // reseed after the drop
			mk_reading(1'b1, rpt_pkg::PROX_HERE, rpt_pkg::TREND_CLOSER, -15360, 360, 0,
				255, rpt_pkg::BLUE_ON)));
		plan.push_back(write_row(rpt_pkg::REG_WEIGHT, rpt_pkg::WEIGHT_ONE));
		plan.push_back(known_row(-8'sd105,
			mk_reading(1'b1, rpt_pkg::PROX_VERY_FAR, rpt_pkg::TREND_FARTHER, -26880, 0,
				rpt_pkg::RED_FULL, 0, rpt_pkg::BLUE_ON)));
		plan.push_back(known_row(-8'sd90,
			mk_reading(1'b1, rpt_pkg::PROX_NEARBY, rpt_pkg::TREND_FARTHER, -23040, 180,
				255, 220, rpt_pkg::BLUE_ON)));
		plan.push_back(write_row(rpt_pkg::REG_WEIGHT, 9'd0));   // zero weight holds
		plan.push_back(sample_row(-8'sd20));
		plan.push_back(write_row(rpt_pkg::REG_WEIGHT, 9'd511)); // above full acts as full
		plan.push_back(sample_row(-8'sd1));
		plan.push_back(write_row(rpt_pkg::REG_THR_HERE, 9'h080));
		plan.push_back(sample_row(-8'sd128));
		plan.push_back(write_row(rpt_pkg::REG_THR_HERE, 9'h17F)); // bit 8 dropped: here threshold at +127
		plan.push_back(sample_row(-8'sd2));
		plan.push_back(write_row(rpt_pkg::REG_MARGIN, 9'd127));
		plan.push_back(sample_row(-8'sd128));
		plan.push_back(write_row(rpt_pkg::REG_MARGIN, 9'd0));
		plan.push_back(sample_row(-8'sd3));
		plan.push_back(sample_row(-8'sd50));
		plan.push_back(sample_row(-8'sd50));
		plan.push_back(sample_row(-8'sd50));
		plan.push_back(sample_row(8'sd0));

		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				quiesce();
				write_reg(plan[i].idx, plan[i].value);
			end else begin
				send_sample(plan[i].value[7:0], plan[i].known, plan[i].want);
			end
		end

		// Random part: nine phases, each with its own register setting. Samples
		// follow a drifting walk so trends show up, with drops and raw bytes mixed in.
		level = -80;
		dir = 1;
		burst = 0;
		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: w = 9'd1;
				1: w = rpt_pkg::WEIGHT_ONE;
				2: w = 9'd511;
				3: w = 9'd0;
				default: w = 9'($urandom_range(1, 256));
			endcase
			case (phase)
				0: mg = 7'd0;
				1: mg = 7'd127;
				2: mg = 7'd64;
				default: mg = 7'($urandom_range(0, 8));
			endcase
			t_here  = 8'(-$urandom_range(60, 90));
			t_close = 8'(int'(t_here) - $urandom_range(0, 10));
			t_near  = 8'(int'(t_close) - $urandom_range(0, 10));
			t_far   = 8'(int'(t_near) - $urandom_range(0, 15));
			case (phase)
				4: begin
					t_here  = -8'sd128;
					t_close = -8'sd128;
					t_near  = -8'sd128;
					t_far   = -8'sd128;
				end
				5: begin
					t_here  = 8'sd127;
					t_close = 8'sd127;
					t_near  = 8'sd127;
					t_far   = 8'sd127;
				end
				6: begin
					// reversed order
					t_here  = -8'sd100;
					t_close = -8'sd93;
					t_near  = -8'sd87;
					t_far   = -8'sd80;
				end
				7: t_here = 8'sd0;
				default: ;
			endcase

			quiesce();
			write_reg(rpt_pkg::REG_WEIGHT, w);
			write_reg(rpt_pkg::REG_THR_HERE, {1'($urandom_range(0, 1)), t_here});
			write_reg(rpt_pkg::REG_THR_CLOSE, {1'($urandom_range(0, 1)), t_close});
			write_reg(rpt_pkg::REG_THR_NEAR, {1'($urandom_range(0, 1)), t_near});
			write_reg(rpt_pkg::REG_THR_FAR, {1'($urandom_range(0, 1)), t_far});
			write_reg(rpt_pkg::REG_MARGIN, {2'($urandom_range(0, 3)), mg});

			for (int n = 0; n < 106; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 6) begin
					x = 8'sd0;
				end else if (roll < 14) begin
					x = 8'($urandom);
				end else if (roll < 16) begin
					x = roll[0] ? 8'sd127 : -8'sd128;
				end else begin
					if ($urandom_range(0, 9) == 0)
						dir = -dir;
					level += dir * $urandom_range(0, 4) + $urandom_range(0, 4) - 2;
					if (level < -125)
						level = -125;
					if (level > -35)
						level = -35;
					x = 8'(level);
				end
				send_sample(x, 1'b0, '0);

				// sender bursts with random gaps, often back to back
				if (burst == 0) begin
					burst = $urandom_range(1, 24);
					gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					if (gap > 0) begin
						@(negedge clk);
						s_tvalid <= 1'b0;
						repeat (gap - 1) @(negedge clk);
					end
				end else begin
					burst--;
				end
			end
		end

		quiesce();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// hang guard: far beyond the slowest legal run
	initial begin
		#1000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
sv/rpt_pkg.sv
sv/rpt_ram.sv
sv/rpt_mac.sv
sv/rssi_proximity_tracker.sv
sim/testbench.sv
